// ===== rtl/frp_pkg.sv =====
// Package for the fixed region partitioner: field widths, register indexes,
// reset values and the result item type. No dependencies.
package frp_pkg;

  localparam int unsigned PosW     = 17;
  localparam int unsigned LenW     = 16;
  localparam int unsigned CntW     = 11;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned SymW     = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [MaskW-1:0] AllowedMaskRst  = 8'd15;
  localparam logic [LenW-1:0]  RegionLengthRst = 16'd20;
  localparam logic [CntW-1:0]  MaxRegionsRst   = 11'd64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAllowedMask  = 2'd0,
    CfgRegionLength = 2'd1,
    CfgMaxRegions   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PosW-1:0] span_begin;
    logic [PosW-1:0] span_end;
    logic            region_valid;
    logic            final_region;
    logic [CntW-1:0] region_total;
  } result_t;

endpackage

// ===== rtl/fixed_region_partitioner.sv =====
// Fixed region partitioner top level: per-symbol region state and result queue.
// Depends on frp_pkg.
//
// Takes one key symbol per cycle while in_ready_o is high and cuts the key
// into regions of span_length allowed symbols; a disallowed symbol restarts
// the open region after it. Each closed region is held back one step so that,
// on the last symbol, its end can stretch to the key end. An item is processed
// in the cycle it is accepted and its zero, one or two results are registered
// in a four-entry result queue, from which the output port reads them;
// in_ready_o is high while the queue has room for two results. A key never
// yields more results than it has symbols and the output port delivers one
// result per cycle, so a new symbol is accepted every cycle and the input stalls
// only while the receiver holds off. Configuration writes take effect the next
// cycle and must only happen while no results are pending.
module fixed_region_partitioner #(
  parameter int unsigned MAX_KEY_LENGTH = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [frp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [frp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [frp_pkg::SymW-1:0]     symbol_i,
  input  logic                         end_of_key_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [frp_pkg::PosW-1:0]     span_begin_o,
  output logic [frp_pkg::PosW-1:0]     span_end_o,
  output logic                         region_valid_o,
  output logic                         final_region_o,
  output logic [frp_pkg::CntW-1:0]     region_total_o
);

  localparam int unsigned KeyPosW = $clog2(MAX_KEY_LENGTH + 1);
  localparam int unsigned Depth   = 4;
  localparam int unsigned PtrW    = $clog2(Depth);
  localparam int unsigned FillW   = $clog2(Depth + 1);

  logic [frp_pkg::MaskW-1:0] allowed_mask_q;
  logic [frp_pkg::LenW-1:0]  span_length_q;
  logic [frp_pkg::CntW-1:0]  max_regions_q;

  logic [KeyPosW-1:0]       key_pos_q, key_pos_d;
  logic [KeyPosW-1:0]       open_start_q, open_start_d;
  logic [frp_pkg::LenW-1:0] open_count_q, open_count_d;
  logic [frp_pkg::CntW-1:0] regions_q, regions_d;
  logic [KeyPosW-1:0]       held_begin_q, held_begin_d;
  logic [KeyPosW-1:0]       held_end_q, held_end_d;
  logic                     held_q, held_d;
  logic                     cutoff_q, cutoff_d;

  logic                     accept;
  logic                     cut;
  logic                     active;
  logic                     allowed;
  logic [KeyPosW-1:0]       next_pos;
  logic [frp_pkg::LenW-1:0] count_inc;
  logic                     close_region;
  logic                     emit_mid;
  logic                     emit_fin;
  logic [KeyPosW-1:0]       fin_end;
  frp_pkg::result_t         mid_res;
  frp_pkg::result_t         fin_res;

  frp_pkg::result_t         fifo_q [Depth];
  logic [PtrW-1:0]          wptr_q, rptr_q;
  logic [FillW-1:0]         fill_q;
  logic                     pop;
  logic [1:0]               n_push;
  frp_pkg::result_t         head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_mask_q <= frp_pkg::AllowedMaskRst;
      span_length_q  <= frp_pkg::RegionLengthRst;
      max_regions_q  <= frp_pkg::MaxRegionsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        frp_pkg::CfgAllowedMask:  allowed_mask_q <= cfg_data_i[frp_pkg::MaskW-1:0];
        frp_pkg::CfgRegionLength: span_length_q  <= cfg_data_i[frp_pkg::LenW-1:0];
        frp_pkg::CfgMaxRegions:   max_regions_q  <= cfg_data_i[frp_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid_i && in_ready_o;
  assign cut      = cutoff_q || (regions_q >= max_regions_q);
  assign active   = !cut && (key_pos_q < KeyPosW'(MAX_KEY_LENGTH));
  assign allowed  = allowed_mask_q[symbol_i];
  assign next_pos = key_pos_q + KeyPosW'(1);
  assign count_inc = (open_count_q == '1) ? open_count_q
                                          : open_count_q + frp_pkg::LenW'(1);
  assign close_region = active && allowed && (span_length_q != '0)
                        && (count_inc == span_length_q);
  assign emit_mid = accept && close_region && held_q;

  // Region state after the symbol, before end-of-key handling
  logic [KeyPosW-1:0]       pos_n, start_n, hbeg_n, hend_n;
  logic [frp_pkg::LenW-1:0] count_n;
  logic [frp_pkg::CntW-1:0] regions_n;
  logic                     held_n;

  always_comb begin
    pos_n     = key_pos_q;
    start_n   = open_start_q;
    count_n   = open_count_q;
    regions_n = regions_q;
    hbeg_n    = held_begin_q;
    hend_n    = held_end_q;
    held_n    = held_q;
    if (active) begin
      pos_n = next_pos;
      if (!allowed) begin
        start_n = next_pos;
        count_n = '0;
      end else if (close_region) begin
        hbeg_n    = open_start_q;
        hend_n    = next_pos;
        held_n    = 1'b1;
        regions_n = regions_q + frp_pkg::CntW'(1);
        start_n   = next_pos;
        count_n   = '0;
      end else begin
        count_n = count_inc;
      end
    end
  end

  assign fin_end = ((count_n != '0) && (start_n == hend_n)) ? pos_n : hend_n;
  assign emit_fin = accept && end_of_key_i;

  always_comb begin
    mid_res.span_begin   = frp_pkg::PosW'(held_begin_q);
    mid_res.span_end     = frp_pkg::PosW'(held_end_q);
    mid_res.region_valid = 1'b1;
    mid_res.final_region = 1'b0;
    mid_res.region_total = '0;
    fin_res.final_region = 1'b1;
    if (held_n) begin
      fin_res.span_begin   = frp_pkg::PosW'(hbeg_n);
      fin_res.span_end     = frp_pkg::PosW'(fin_end);
      fin_res.region_valid = 1'b1;
      fin_res.region_total = regions_n;
    end else begin
      fin_res.span_begin   = '0;
      fin_res.span_end     = '0;
      fin_res.region_valid = 1'b0;
      fin_res.region_total = '0;
    end
  end

  always_comb begin
    key_pos_d    = key_pos_q;
    open_start_d = open_start_q;
    open_count_d = open_count_q;
    regions_d    = regions_q;
    held_begin_d = held_begin_q;
    held_end_d   = held_end_q;
    held_d       = held_q;
    cutoff_d     = cutoff_q;
    if (accept) begin
      if (end_of_key_i) begin
        key_pos_d    = '0;
        open_start_d = '0;
        open_count_d = '0;
        regions_d    = '0;
        held_begin_d = '0;
        held_end_d   = '0;
        held_d       = 1'b0;
        cutoff_d     = 1'b0;
      end else begin
        key_pos_d    = pos_n;
        open_start_d = start_n;
        open_count_d = count_n;
        regions_d    = regions_n;
        held_begin_d = hbeg_n;
        held_end_d   = hend_n;
        held_d       = held_n;
        cutoff_d     = cut;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q    <= '0;
      open_start_q <= '0;
      open_count_q <= '0;
      regions_q    <= '0;
      held_begin_q <= '0;
      held_end_q   <= '0;
      held_q       <= 1'b0;
      cutoff_q     <= 1'b0;
    end else begin
      key_pos_q    <= key_pos_d;
      open_start_q <= open_start_d;
      open_count_q <= open_count_d;
      regions_q    <= regions_d;
      held_begin_q <= held_begin_d;
      held_end_q   <= held_end_d;
      held_q       <= held_d;
      cutoff_q     <= cutoff_d;
    end
  end

  // Result queue
  assign pop    = out_valid_o && out_ready_i;
  assign n_push = {1'b0, emit_mid} + {1'b0, emit_fin};

  always_ff @(posedge clk_i) begin
    if (emit_mid) begin
      fifo_q[wptr_q] <= mid_res;
    end
    if (emit_fin) begin
      fifo_q[wptr_q + PtrW'(emit_mid)] <= fin_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_q + PtrW'(n_push);
      if (pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      fill_q <= fill_q + FillW'(n_push) - FillW'(pop);
    end
  end

  assign in_ready_o  = (fill_q <= FillW'(Depth - 2));
  assign out_valid_o = (fill_q != '0);
  assign head        = fifo_q[rptr_q];

  assign span_begin_o   = head.span_begin;
  assign span_end_o     = head.span_end;
  assign region_valid_o = head.region_valid;
  assign final_region_o = head.final_region;
  assign region_total_o = head.region_total;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Depth))
    else $error("result queue overfilled");

  a_held_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == (regions_q != '0))
    else $error("held region flag disagrees with region count");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_pos_q <= KeyPosW'(MAX_KEY_LENGTH))
    else $error("key position beyond maximum key length");

  a_key_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_key_i |=> (key_pos_q == '0) && !held_q && !cutoff_q)
    else $error("key state not cleared after last symbol");

endmodule
